>>> src/assert_macros.svh
// assertion macros used by the checker file rmdd_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst_sig is high
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while rst_sig is high
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/rmdd_pkg.sv
// types and constants of the running max drawdown tracker
// no dependencies; imported by every module of the block
package rmdd_pkg;

  localparam int SUM_W     = 48;
  localparam int IDX_W     = 24;
  localparam int AMT_W     = 32;
  localparam int RF_W      = 32;
  localparam int FRAC_W    = 16;
  // integer bits of the ratio below the sign bit
  localparam int OVF_SH    = RF_W - 1 - FRAC_W;
  localparam int DIV_STEPS = RF_W - 1;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef struct packed {
    logic                    first_of_series;
    logic signed [AMT_W-1:0] pnl_amount;
  } in_item_t;

  typedef struct packed {
    logic        [SUM_W-1:0] cur_dd;
    logic signed [SUM_W-1:0] cumulative_total;
    logic        [SUM_W-1:0] peak_dd;
    logic        [IDX_W-1:0] peak_dd_span;
    logic signed [RF_W-1:0]  recovery_q16;
  } result_t;

  // classified item handed from the front end to the divider
  typedef struct packed {
    logic        [SUM_W-1:0] cur_dd;
    logic signed [SUM_W-1:0] cumulative_total;
    logic        [SUM_W-1:0] peak_dd;
    logic        [IDX_W-1:0] peak_dd_span;
  } entry_t;

  localparam logic [RF_W-1:0] RF_MAX = {1'b0, {(RF_W-1){1'b1}}};
  localparam logic [RF_W-1:0] RF_MIN = {1'b1, {(RF_W-1){1'b0}}};

endpackage

>>> src/rmdd_front.sv
// front end: running sum, peak and drawdown recurrence, one transaction a cycle while accept is high
// depends on rmdd_pkg
module rmdd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  rmdd_pkg::in_item_t item,
  output rmdd_pkg::entry_t  entry
);
  import rmdd_pkg::*;

  logic signed [SUM_W-1:0] sum, peak;
  logic        [SUM_W-1:0] deepest;
  logic        [IDX_W-1:0] pos, drop_began, deep_began, deep_ended;
  logic                    in_drop;

  logic signed [SUM_W:0]   ext_sum;
  logic signed [SUM_W-1:0] sum_next, peak_next, amt_ext;
  logic        [SUM_W-1:0] dd, deepest_base, deepest_next;
  logic        [IDX_W-1:0] pos_next, drop_began_next, deep_began_base, deep_ended_base;
  logic        [IDX_W-1:0] deep_began_next, deep_ended_next;
  logic                    in_drop_base, in_drop_next;

  always_comb begin
    amt_ext = {{(SUM_W-AMT_W){item.pnl_amount[AMT_W-1]}}, item.pnl_amount};
    ext_sum = {sum[SUM_W-1], sum} + {amt_ext[SUM_W-1], amt_ext};
    if (item.first_of_series) begin
      sum_next        = amt_ext;
      peak_next       = amt_ext;
      pos_next        = '0;
      deepest_base    = '0;
      in_drop_base    = 1'b0;
      drop_began_next = '0;
      deep_began_base = '0;
      deep_ended_base = '0;
    end else begin
      // saturate on signed overflow of the total
      if (ext_sum[SUM_W] != ext_sum[SUM_W-1]) begin
        sum_next = ext_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_next = ext_sum[SUM_W-1:0];
      end
      peak_next       = (sum_next > peak) ? sum_next : peak;
      pos_next        = (pos != '1) ? pos + 1'b1 : pos;
      deepest_base    = deepest;
      in_drop_base    = in_drop;
      drop_began_next = drop_began;
      deep_began_base = deep_began;
      deep_ended_base = deep_ended;
    end
    dd = peak_next - sum_next;
    in_drop_next = in_drop_base;
    if (dd != '0 && !in_drop_base) begin
      in_drop_next    = 1'b1;
      drop_began_next = pos_next;
    end else if (dd == '0 && in_drop_base) begin
      in_drop_next = 1'b0;
    end
    if (dd > deepest_base) begin
      deepest_next    = dd;
      deep_began_next = drop_began_next;
      deep_ended_next = pos_next;
    end else begin
      deepest_next    = deepest_base;
      deep_began_next = deep_began_base;
      deep_ended_next = deep_ended_base;
    end
    entry.cur_dd           = dd;
    entry.cumulative_total = sum_next;
    entry.peak_dd          = deepest_next;
    entry.peak_dd_span     = deep_ended_next - deep_began_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      peak       <= '0;
      deepest    <= '0;
      pos        <= '0;
      drop_began <= '0;
      deep_began <= '0;
      deep_ended <= '0;
      in_drop    <= 1'b0;
    end else if (accept) begin
      sum        <= sum_next;
      peak       <= peak_next;
      deepest    <= deepest_next;
      pos        <= pos_next;
      drop_began <= drop_began_next;
      deep_began <= deep_began_next;
      deep_ended <= deep_ended_next;
      in_drop    <= in_drop_next;
    end
  end

endmodule

>>> src/rmdd_queue.sv
// short queue between front end and divider back end
// depends on rmdd_pkg
module rmdd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  rmdd_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             take,
  output logic             avail,
  output rmdd_pkg::entry_t head
);
  import rmdd_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/rmdd_back.sv
// back end: bit-serial signed q16.16 divider and the result register
// depends on rmdd_pkg
module rmdd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  rmdd_pkg::entry_t  head,
  output logic              take,
  output logic              empty,
  input  logic              pop,
  output rmdd_pkg::result_t result
);
  import rmdd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t                 state;
  entry_t                 ent;
  logic                   neg;
  logic [SUM_W-1:0]       mag, den, rem;
  logic [DIV_STEPS-1:0]   nb, quo;
  logic [CNT_W-1:0]       cnt;
  logic [RF_W-1:0]        rf;
  logic                   out_valid;

  logic [SUM_W:0]         r2;
  logic                   ge;
  logic [SUM_W-1:0]       tot_u;
  logic                   pop_fire;
  logic                   load_result;

  assign take        = (state == S_IDLE) && avail;
  assign empty       = !out_valid;
  assign pop_fire    = pop && out_valid;
  assign tot_u       = head.cumulative_total;
  assign load_result = (state == S_DONE) && (!out_valid || pop_fire);

  always_comb begin
    r2 = {rem, nb[DIV_STEPS-1]};
    ge = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (pop_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (avail) begin
            ent <= head;
            neg <= tot_u[SUM_W-1];
            mag <= tot_u[SUM_W-1] ? (~tot_u + 1'b1) : tot_u;
            den <= head.peak_dd;
            if (head.peak_dd == '0) begin
              rf    <= '0;
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // integer part too large for q16.16
          if ({{OVF_SH{1'b0}}, mag} >= {den, {OVF_SH{1'b0}}}) begin
            rf    <= neg ? RF_MIN : RF_MAX;
            state <= S_DONE;
          end else begin
            rem   <= mag >> OVF_SH;
            nb    <= {mag[OVF_SH-1:0], {FRAC_W{1'b0}}};
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? SUM_W'(r2 - {1'b0, den}) : r2[SUM_W-1:0];
          quo <= {quo[DIV_STEPS-2:0], ge};
          nb  <= nb << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          rf    <= neg ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_result) begin
            result.cur_dd           <= ent.cur_dd;
            result.cumulative_total <= ent.cumulative_total;
            result.peak_dd          <= ent.peak_dd;
            result.peak_dd_span     <= ent.peak_dd_span;
            result.recovery_q16     <= rf;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/running_max_drawdown_tracker_top.sv
// top level of the running max drawdown tracker
// depends on rmdd_pkg, rmdd_front, rmdd_queue and rmdd_back
//
// usage
// - input: an item transaction happens on a rising edge with push high and
//   full low; item carries the start flag and the signed pnl amount
// - output: while empty is low the oldest result sits on result, and a
//   transaction happens on an edge with pop high; one result per item, in order
// - the front end updates the sum, peak and drawdown state in the cycle of
//   the transaction and files the classified item into a four-entry queue
// - the back end takes one item at a time: load, range check, 31 divide
//   steps of one quotient bit each, sign fix and hand-over; with zero max
//   drawdown it skips from load to hand-over, a saturating ratio from the
//   range check to hand-over; no new item is taken before hand-over
// - from idle five items enter back to back
// - a stalled receiver holds the result register, the back end parks the
//   next result, the queue fills and full goes high
// - synchronous reset clears the series state, the queue and the output
//   valid flag; a first item without the start flag runs on from a zero total and peak
module running_max_drawdown_tracker_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rmdd_pkg::in_item_t item,
  output logic              empty,
  input  logic              pop,
  output rmdd_pkg::result_t result
);
  import rmdd_pkg::*;

  entry_t front_entry;
  entry_t q_head;
  logic   accept;
  logic   q_avail;
  logic   q_take;

  // an item enters only when the queue has a free slot
  assign accept = push && !full;

  rmdd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .entry (front_entry)
  );

  rmdd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_entry(front_entry),
    .full    (full),
    .take    (q_take),
    .avail   (q_avail),
    .head    (q_head)
  );

  // divider and result register
  rmdd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (q_avail),
    .head  (q_head),
    .take  (q_take),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule

>>> src/rmdd_checker.sv
// port-level checks of the running max drawdown tracker, bound to the top
// depends on rmdd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rmdd_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input rmdd_pkg::in_item_t item,
  input logic              empty,
  input logic              pop,
  input rmdd_pkg::result_t result
);
  import rmdd_pkg::*;

  // reset leaves no result waiting
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty)
  // a result not taken stays put
  `ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result))
  // the queue only fills through transactions
  `ASSERT_NEXT(a_full_needs_push, clk, rst, !full && !push, !full)
  // the deepest drawdown is never shallower than the current one
  `ASSERT_IMPLIES(a_max_ge_cur, clk, rst, !empty, result.peak_dd >= result.cur_dd)
  // no drawdown gives a zero recovery factor
  `ASSERT_IMPLIES(a_zero_rf, clk, rst, !empty && result.peak_dd == '0, result.recovery_q16 == '0)

endmodule

bind running_max_drawdown_tracker_top rmdd_checker u_rmdd_checker (.*);
